// ----- hw/rtl/lma_pkg.sv -----
// Package for the Legendre moment accumulator: item and configuration types,
// controller states, fixed-point constants and a small clamp helper.
// No dependencies.
package lma_pkg;

    // Field widths
    localparam int IDX_W   = 12;
    localparam int DEG_W   = 4;
    localparam int CELLS_W = 13;
    localparam int WORD_W  = 32;
    localparam int SUM_W   = 64;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_AREA    = 3'd7;

    // Divider geometry: dividend left-aligned, quotient in the low bits
    localparam int DIV_W   = 63;
    localparam int DVS_W   = 33;
    localparam int DCNT_W  = 6;
    localparam logic [DCNT_W-1:0] ITERS_COORD = 6'd43;
    localparam logic [DCNT_W-1:0] ITERS_NORM  = 6'd63;
    localparam logic [DCNT_W-1:0] ITERS_POLY  = 6'd36;

    // Queue between intake and datapath
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    // Coordinate / value division selector
    typedef enum logic [1:0] {
        DSEL_X,
        DSEL_Y,
        DSEL_V
    } lma_dsel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_POLY_INIT,
        ST_POLY_TEST,
        ST_POLY_MUL,
        ST_POLY_NUM,
        ST_POLY_WAIT,
        ST_POLY_STORE,
        ST_PROD_1,
        ST_PROD_1R,
        ST_PROD_2,
        ST_PROD_2R,
        ST_AREA,
        ST_ACCUM,
        ST_SCALE_LO,
        ST_SCALE_HI,
        ST_EMIT
    } lma_state_t;

    typedef struct packed {
        logic [IDX_W-1:0]         col;
        logic [IDX_W-1:0]         row;
        logic signed [WORD_W-1:0] cell_value;
        logic signed [WORD_W-1:0] weight;
        logic                     last;
    } lma_item_t;

    typedef struct packed {
        logic [DEG_W-1:0]         degree_x;
        logic [DEG_W-1:0]         degree_y;
        logic [DEG_W-1:0]         degree_value;
        logic signed [WORD_W-1:0] min_value;
        logic signed [WORD_W-1:0] max_value;
        logic [CELLS_W-1:0]       cells_x;
        logic [CELLS_W-1:0]       cells_y;
        logic [WORD_W-1:0]        cell_area;
    } lma_cfg_t;

    // Clamp a signed 40-bit value to [-1,1] in Q2.30
    function automatic logic signed [31:0] clamp_q30(input logic signed [39:0] v);
        logic signed [39:0] one40;
        one40 = 40'sd1073741824;
        if (v > one40) begin
            return ONE_Q30;
        end
        if (v < -one40) begin
            return -ONE_Q30;
        end
        return v[31:0];
    endfunction

endpackage

// ----- hw/rtl/lma_queue.sv -----
// Intake side: accepts cell transactions and buffers them in a short queue
// ahead of the datapath. Depends on lma_pkg.
module lma_queue
    import lma_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  lma_item_t push_item,
    output logic      ready,
    input  logic      pop,
    output logic      avail,
    output lma_item_t head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lma_item_t        store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign avail = (count_reg != '0);
    assign head  = store_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the entry payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/lma_div.sv -----
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// The dividend is left-aligned by the caller. Depends on lma_pkg.
module lma_div
    import lma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    input  logic [DCNT_W-1:0] iters,
    output logic              busy,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic [DIV_W-1:0]  sh_reg, sh_next;
    logic [DVS_W:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = sh_reg;

    // Shift in one dividend bit, subtract when it fits
    always_comb
    begin
        trial     = {rem_reg[DVS_W-1:0], sh_reg[DIV_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next  = {sh_reg[DIV_W-2:0], fits};
            rem_next = fits ? (trial - {1'b0, dvs_reg}) : trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ----- hw/rtl/lma_core.sv -----
// Datapath sequencer: coordinates, normalization, Legendre recurrences,
// product, accumulation and output scaling. Depends on lma_pkg and lma_div.
module lma_core
    import lma_pkg::*;
#(
    parameter int MAX_DEGREE = 15,
    parameter int GRID_MAX   = 4096
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lma_cfg_t           cfg,
    input  logic               q_avail,
    input  lma_item_t          q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] moment
);

    lma_state_t          state_reg, state_next;
    lma_item_t           item_reg, item_next;
    lma_dsel_t           dsel_reg, dsel_next;
    lma_dsel_t           psel_reg, psel_next;
    logic signed [31:0]  xs_reg, xs_next;
    logic signed [31:0]  ys_reg, ys_next;
    logic signed [31:0]  ts_reg, ts_next;
    logic signed [31:0]  px_reg, px_next;
    logic signed [31:0]  py_reg, py_next;
    logic signed [31:0]  prev_reg, prev_next;
    logic signed [31:0]  cur_reg, cur_next;
    logic signed [31:0]  p_reg, p_next;
    logic [DEG_W-1:0]    n_reg, n_next;
    logic [DEG_W-1:0]    deg_reg, deg_next;
    logic                neg_reg, neg_next;
    logic signed [63:0]  prod_reg, prod_next;
    logic [63:0]         lo_reg, lo_next;
    logic signed [63:0]  sum_reg, sum_next;
    logic                out_valid_reg, out_valid_next;
    logic signed [63:0]  moment_reg, moment_next;

    // Divider interface
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DCNT_W-1:0] div_iters;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_q;

    // Shared multiplier
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_full;

    // Working values
    logic [DVS_W-1:0]   cells_div;
    logic [DEG_W-1:0]   deg_sel;
    logic [DEG_W-1:0]   deg_cfg;
    logic signed [31:0] poly_arg;
    logic signed [32:0] norm_num;
    logic signed [32:0] norm_den;
    logic signed [31:0] coord_val;
    logic signed [63:0] rnd30;
    logic signed [39:0] r40;
    logic signed [39:0] num40;
    logic signed [39:0] mag40;
    logic signed [39:0] nxt40;
    logic signed [63:0] term;
    logic signed [64:0] sum65;
    logic [31:0]        w_mag;
    logic [63:0]        s_mag;
    logic               m_neg;
    logic [63:0]        limit;
    logic [63:0]        part;
    logic [63:0]        hi_sh;
    logic [63:0]        mag;
    logic               m_sat;

    lma_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .iters    (div_iters),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid = out_valid_reg;
    assign moment    = moment_reg;
    assign mul_full  = mul_a * mul_b;

    // Derived operands
    always_comb
    begin
        if (dsel_reg == DSEL_X)
        begin
            cells_div = {20'b0, cfg.cells_x};
        end
        else
        begin
            cells_div = {20'b0, cfg.cells_y};
        end
        if (cells_div == '0)
        begin
            cells_div = DVS_W'(1);
        end
        else if (cells_div > DVS_W'(GRID_MAX))
        begin
            cells_div = DVS_W'(GRID_MAX);
        end

        case (psel_reg)
            DSEL_X:  deg_cfg = cfg.degree_x;
            DSEL_Y:  deg_cfg = cfg.degree_y;
            default: deg_cfg = cfg.degree_value;
        endcase
        deg_sel = (32'(deg_cfg) > MAX_DEGREE) ? DEG_W'(MAX_DEGREE) : deg_cfg;

        case (psel_reg)
            DSEL_X:  poly_arg = xs_reg;
            DSEL_Y:  poly_arg = ys_reg;
            default: poly_arg = ts_reg;
        endcase

        norm_num = {item_reg.cell_value[31], item_reg.cell_value}
                 - {cfg.min_value[31], cfg.min_value};
        norm_den = {cfg.max_value[31], cfg.max_value}
                 - {cfg.min_value[31], cfg.min_value};

        coord_val = (div_q >= DIV_W'(64'h8000_0000)) ? ONE_Q30
                  : ($signed(div_q[31:0]) - ONE_Q30);

        // Round a Q4.60 product to Q2.30, halves up
        rnd30 = (prod_reg + 64'sd536870912) >>> 30;
        r40   = rnd30[39:0];
        num40 = $signed({35'b0, n_reg, 1'b1}) * r40
              - $signed({36'b0, n_reg}) * {{8{prev_reg[31]}}, prev_reg};
        mag40 = num40[39] ? -num40 : num40;
        nxt40 = neg_reg ? -$signed({4'b0, div_q[35:0]}) : $signed({4'b0, div_q[35:0]});

        // Area product to Q32.32 and saturating accumulate
        term  = (prod_reg + 64'sd8192) >>> 14;
        sum65 = {sum_reg[63], sum_reg} + {term[63], term};

        // Output scaling on magnitudes
        w_mag = item_reg.weight[31] ? 32'(-item_reg.weight) : 32'(item_reg.weight);
        s_mag = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
        m_neg = item_reg.weight[31] ^ sum_reg[63];
        limit = m_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        part  = 64'(({1'b0, lo_reg} + 65'h8000) >> 16);
        hi_sh = 64'(prod_reg) << 16;
        m_sat = (64'(prod_reg) >= 64'h0000_8000_0000_0000) || (part > limit)
              || (hi_sh > limit - part);
        mag   = m_sat ? limit : hi_sh + part;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        dsel_next      = dsel_reg;
        psel_next      = psel_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        ts_next        = ts_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        deg_next       = deg_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        lo_next        = lo_reg;
        sum_next       = sum_reg;
        moment_next    = moment_reg;
        out_valid_next = out_valid_reg;
        q_pop          = 1'b0;
        div_start      = 1'b0;
        div_dividend   = '0;
        div_divisor    = '0;
        div_iters      = ITERS_COORD;
        mul_a          = '0;
        mul_b          = '0;

        // Drop the result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_avail)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_head;
                    dsel_next  = DSEL_X;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                if (dsel_reg == DSEL_V)
                begin
                    if (norm_den <= 0 || norm_num <= 0)
                    begin
                        ts_next    = '0;
                        psel_next  = DSEL_X;
                        state_next = ST_POLY_INIT;
                    end
                    else if (norm_num >= norm_den)
                    begin
                        ts_next    = ONE_Q30;
                        psel_next  = DSEL_X;
                        state_next = ST_POLY_INIT;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = {norm_num, 30'b0};
                        div_divisor  = norm_den;
                        div_iters    = ITERS_NORM;
                        state_next   = ST_DIV_WAIT;
                    end
                end
                else
                begin
                    div_start = 1'b1;
                    if (dsel_reg == DSEL_X)
                    begin
                        div_dividend = {item_reg.col, 1'b1, 50'b0};
                    end
                    else
                    begin
                        div_dividend = {item_reg.row, 1'b1, 50'b0};
                    end
                    div_divisor = cells_div;
                    div_iters   = ITERS_COORD;
                    state_next  = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (dsel_reg)
                        DSEL_X:
                        begin
                            xs_next    = coord_val;
                            dsel_next  = DSEL_Y;
                            state_next = ST_DIV_GO;
                        end
                        DSEL_Y:
                        begin
                            ys_next    = coord_val;
                            dsel_next  = DSEL_V;
                            state_next = ST_DIV_GO;
                        end
                        default:
                        begin
                            ts_next    = $signed({2'b0, div_q[29:0]});
                            psel_next  = DSEL_X;
                            state_next = ST_POLY_INIT;
                        end
                    endcase
                end
            end
            ST_POLY_INIT:
            begin
                deg_next   = deg_sel;
                prev_next  = ONE_Q30;
                cur_next   = (deg_sel == '0) ? ONE_Q30 : poly_arg;
                n_next     = DEG_W'(1);
                state_next = ST_POLY_TEST;
            end
            ST_POLY_TEST:
            begin
                state_next = (n_reg < deg_reg) ? ST_POLY_MUL : ST_POLY_STORE;
            end
            ST_POLY_MUL:
            begin
                mul_a      = {poly_arg[31], poly_arg};
                mul_b      = {cur_reg[31], cur_reg};
                prod_next  = mul_full[63:0];
                state_next = ST_POLY_NUM;
            end
            ST_POLY_NUM:
            begin
                div_start    = 1'b1;
                div_dividend = {mag40[35:0], 27'b0};
                div_divisor  = {28'b0, 5'({1'b0, n_reg} + 5'd1)};
                div_iters    = ITERS_POLY;
                neg_next     = num40[39];
                state_next   = ST_POLY_WAIT;
            end
            ST_POLY_WAIT:
            begin
                if (div_done)
                begin
                    prev_next  = cur_reg;
                    cur_next   = clamp_q30(nxt40);
                    n_next     = n_reg + 1'b1;
                    state_next = ST_POLY_TEST;
                end
            end
            ST_POLY_STORE:
            begin
                case (psel_reg)
                    DSEL_X:
                    begin
                        px_next    = cur_reg;
                        psel_next  = DSEL_Y;
                        state_next = ST_POLY_INIT;
                    end
                    DSEL_Y:
                    begin
                        py_next    = cur_reg;
                        psel_next  = DSEL_V;
                        state_next = ST_POLY_INIT;
                    end
                    default:
                    begin
                        state_next = ST_PROD_1;
                    end
                endcase
            end
            ST_PROD_1:
            begin
                mul_a      = {px_reg[31], px_reg};
                mul_b      = {py_reg[31], py_reg};
                prod_next  = mul_full[63:0];
                state_next = ST_PROD_1R;
            end
            ST_PROD_1R:
            begin
                p_next     = rnd30[31:0];
                state_next = ST_PROD_2;
            end
            ST_PROD_2:
            begin
                mul_a      = {p_reg[31], p_reg};
                mul_b      = {cur_reg[31], cur_reg};
                prod_next  = mul_full[63:0];
                state_next = ST_PROD_2R;
            end
            ST_PROD_2R:
            begin
                p_next     = rnd30[31:0];
                state_next = ST_AREA;
            end
            ST_AREA:
            begin
                mul_a      = {p_reg[31], p_reg};
                mul_b      = $signed({1'b0, cfg.cell_area});
                prod_next  = mul_full[63:0];
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                if (sum65[64] != sum65[63])
                begin
                    sum_next = sum65[64] ? 64'sh8000_0000_0000_0000
                                         : 64'sh7FFF_FFFF_FFFF_FFFF;
                end
                else
                begin
                    sum_next = sum65[63:0];
                end
                state_next = item_reg.last ? ST_SCALE_LO : ST_IDLE;
            end
            ST_SCALE_LO:
            begin
                mul_a      = $signed({1'b0, w_mag});
                mul_b      = $signed({1'b0, s_mag[31:0]});
                prod_next  = mul_full[63:0];
                state_next = ST_SCALE_HI;
            end
            ST_SCALE_HI:
            begin
                lo_next    = 64'(prod_reg);
                mul_a      = $signed({1'b0, w_mag});
                mul_b      = $signed({1'b0, s_mag[63:32]});
                prod_next  = mul_full[63:0];
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg)
                begin
                    moment_next    = m_neg ? $signed(-mag) : $signed(mag);
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        dsel_reg   <= dsel_next;
        psel_reg   <= psel_next;
        xs_reg     <= xs_next;
        ys_reg     <= ys_next;
        ts_reg     <= ts_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        deg_reg    <= deg_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
        lo_reg     <= lo_next;
        moment_reg <= moment_next;
    end

`ifndef NO_ASSERTIONS
    // The divider is never restarted mid-operation
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // A result ready to leave is registered in the next cycle
    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !out_valid_reg) |=> out_valid_reg && sum_reg == '0)
        else $error("result not loaded or sum not cleared");

    // A recurrence step only runs below the target degree
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POLY_MUL) |-> (n_reg < deg_reg))
        else $error("recurrence step beyond degree");
`endif

endmodule

// ----- hw/rtl/legendre_moment_accumulator.sv -----
// Legendre moment accumulator over a 2-D grid.
// Cell transactions enter on in_valid/in_stall with col, row, cell_value,
// weight and last. Configuration is a plain write port (cfg_we, cfg_index,
// cfg_wdata); the user must write it only while the block is idle, as the
// block itself does not enforce this. Each accepted cell is buffered in a
// two-entry queue, then the datapath maps the cell to x, y in [-1,1] and the
// value to [0,1] (up to three passes of a shared one-bit-per-cycle divider),
// evaluates three Legendre recurrences (per step one multiply and one
// division) and adds the product, scaled by the cell area, to a saturating
// Q32.32 sum.
// On a cell marked last, moment = weight * sum leaves on out_valid/out_stall
// after the accumulation and scaling states, and the sum is cleared.
// in_stall rises when the queue is full. A stalled result holds in the output
// register; the datapath waits only when a second result is ready behind it.
// Reset clears the sum, the queue and the output; registers take reset values.
module legendre_moment_accumulator
    import lma_pkg::*;
#(
    parameter int MAX_DEGREE = 15,
    parameter int GRID_MAX   = 4096
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [11:0]             col,
    input  logic [11:0]             row,
    input  logic signed [31:0]      cell_value,
    input  logic signed [31:0]      weight,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [63:0]      moment,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]             cfg_wdata
);

    lma_cfg_t  cfg_reg, cfg_next;
    lma_item_t in_item;
    lma_item_t q_head;
    logic      q_ready;
    logic      q_avail;
    logic      q_pop;

    // Register file writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEGREE_X:     cfg_next.degree_x     = cfg_wdata[DEG_W-1:0];
                REG_DEGREE_Y:     cfg_next.degree_y     = cfg_wdata[DEG_W-1:0];
                REG_DEGREE_VALUE: cfg_next.degree_value = cfg_wdata[DEG_W-1:0];
                REG_MIN_VALUE:    cfg_next.min_value    = $signed(cfg_wdata);
                REG_MAX_VALUE:    cfg_next.max_value    = $signed(cfg_wdata);
                REG_CELLS_X:      cfg_next.cells_x      = cfg_wdata[CELLS_W-1:0];
                REG_CELLS_Y:      cfg_next.cells_y      = cfg_wdata[CELLS_W-1:0];
                REG_CELL_AREA:    cfg_next.cell_area    = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.degree_x     <= '0;
            cfg_reg.degree_y     <= '0;
            cfg_reg.degree_value <= '0;
            cfg_reg.min_value    <= '0;
            cfg_reg.max_value    <= 32'sd65536;
            cfg_reg.cells_x      <= CELLS_W'(1);
            cfg_reg.cells_y      <= CELLS_W'(1);
            cfg_reg.cell_area    <= 32'd65536;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pack the incoming transaction
    assign in_item.col        = col;
    assign in_item.row        = row;
    assign in_item.cell_value = cell_value;
    assign in_item.weight     = weight;
    assign in_item.last       = last;
    assign in_stall           = !q_ready;

    lma_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !in_stall),
        .push_item (in_item),
        .ready     (q_ready),
        .pop       (q_pop),
        .avail     (q_avail),
        .head      (q_head)
    );

    lma_core #(
        .MAX_DEGREE (MAX_DEGREE),
        .GRID_MAX   (GRID_MAX)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_avail   (q_avail),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .moment    (moment)
    );

endmodule

// ----- tb/sv/tb_legendre_moment_accumulator.sv -----
// Testbench for legendre_moment_accumulator: random and directed cell transactions
// checked against a fixed-point moment predictor kept in a small scoreboard class.
// Depends on lma_pkg and the legendre_moment_accumulator RTL.
module tb_legendre_moment_accumulator;
    timeunit 1ns;
    timeprecision 1ps;
    import lma_pkg::*;

    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam int     GRID_LIMIT = 4096;
    localparam int     DEG_LIMIT  = 15;
    localparam int     STALL_LIMIT = 40000;

    // Moment predictor and store of pending moments
    class moment_board;
        lma_cfg_t cfg;
        longint   grid_sum;
        longint   moments_due[$];
        int       errors;
        int       moments_seen;
        int       cells_seen;

        function new();
            cfg.degree_x = '0;
            cfg.degree_y = '0;
            cfg.degree_value = '0;
            cfg.min_value = 32'sd0;
            cfg.max_value = 32'sd65536;
            cfg.cells_x = 13'd1;
            cfg.cells_y = 13'd1;
            cfg.cell_area = 32'd65536;
            grid_sum = 0;
            errors = 0;
            moments_seen = 0;
            cells_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_DEGREE_X:     cfg.degree_x = data[3:0];
                REG_DEGREE_Y:     cfg.degree_y = data[3:0];
                REG_DEGREE_VALUE: cfg.degree_value = data[3:0];
                REG_MIN_VALUE:    cfg.min_value = data;
                REG_MAX_VALUE:    cfg.max_value = data;
                REG_CELLS_X:      cfg.cells_x = data[12:0];
                REG_CELLS_Y:      cfg.cells_y = data[12:0];
                REG_CELL_AREA:    cfg.cell_area = data;
                default:          ;
            endcase
        endfunction

        // Round to nearest, halves toward plus infinity
        function longint round_shift(longint v, int s);
            longint w;
            w = v + (64'sd1 <<< (s - 1));
            return w >>> s;
        endfunction

        function longint clamp_unit(longint v);
            if (v > Q30_ONE) return Q30_ONE;
            if (v < -Q30_ONE) return -Q30_ONE;
            return v;
        endfunction

        function longint grid_coord(logic [11:0] idx, logic [12:0] cells);
            longint c;
            longint q;
            c = longint'(cells);
            if (c == 0) c = 1;
            if (c > GRID_LIMIT) c = GRID_LIMIT;
            q = (((2 * longint'(idx)) + 1) <<< 30) / c - Q30_ONE;
            return clamp_unit(q);
        endfunction

        function longint legendre_at(logic [3:0] deg, longint x);
            longint prev;
            longint cur;
            longint nxt;
            int d;
            d = int'(deg);
            if (d > DEG_LIMIT) d = DEG_LIMIT;
            if (d == 0) return Q30_ONE;
            prev = Q30_ONE;
            cur = x;
            for (int n = 1; n < d; n++)
            begin
                nxt = ((2 * n + 1) * round_shift(x * cur, 30) - n * prev) / (n + 1);
                prev = cur;
                cur = clamp_unit(nxt);
            end
            return cur;
        endfunction

        function longint norm_value(logic signed [31:0] v);
            longint num;
            longint den;
            num = longint'(v) - longint'(cfg.min_value);
            den = longint'(cfg.max_value) - longint'(cfg.min_value);
            if (den <= 0 || num <= 0) return 0;
            if (num >= den) return Q30_ONE;
            return (num <<< 30) / den;
        endfunction

        function longint sat_sum(longint a, longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
                return a[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            return s;
        endfunction

        // Weight times sum, Q16.16 by Q32.32 down to Q32.32, saturating
        function longint weigh_sum(longint w, longint s);
            bit neg;
            bit [63:0] a, b, lo, hi, part, mag, lim;
            neg = (w < 0) != (s < 0);
            a = (w < 0) ? -w : w;
            b = (s < 0) ? -s : s;
            lo = a * {32'd0, b[31:0]};
            hi = a * {32'd0, b[63:32]};
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            if (hi >= 64'h0000_8000_0000_0000)
                mag = lim;
            else
            begin
                part = (lo + 64'h8000) >> 16;
                mag = hi << 16;
                if (part > lim || mag > lim - part)
                    mag = lim;
                else
                    mag = mag + part;
            end
            return neg ? -mag : mag;
        endfunction

        function void note_cell(lma_item_t it);
            longint p;
            longint term;
            p = round_shift(legendre_at(cfg.degree_x, grid_coord(it.col, cfg.cells_x)) *
                legendre_at(cfg.degree_y, grid_coord(it.row, cfg.cells_y)), 30);
            p = round_shift(p * legendre_at(cfg.degree_value, norm_value(it.cell_value)), 30);
            term = round_shift(p * longint'({32'd0, cfg.cell_area}), 14);
            grid_sum = sat_sum(grid_sum, term);
            cells_seen++;
            if (it.last)
            begin
                moments_due = {moments_due, weigh_sum(longint'(it.weight), grid_sum)};
                grid_sum = 0;
            end
        endfunction

        function void check_moment(logic signed [63:0] got);
            longint want;
            moments_seen++;
            if (moments_due.size() == 0)
            begin
                $error("unexpected moment %0d", got);
                errors++;
                return;
            end
            want = moments_due.pop_front();
            if (got !== want)
            begin
                $error("moment mismatch: expected %0d actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [11:0] col = '0;
    logic [11:0] row = '0;
    logic signed [31:0] cell_value = '0;
    logic signed [31:0] weight = '0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [63:0] moment;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    moment_board board = new();
    bit gaps_on = 1'b1;
    int quiet_cycles = 0;

    legendre_moment_accumulator uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .col(col), .row(row), .cell_value(cell_value), .weight(weight), .last(last),
        .out_valid(out_valid), .out_stall(out_stall), .moment(moment),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check results; randomize the result stall between edges
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                board.check_moment(moment);
            @(negedge clk);
            out_stall = gaps_on && ($urandom_range(0, 99) < 34);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("legendre_moment_accumulator test failed");
            $finish;
        end
    end

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_cfg(int dx, int dy, int dv, logic [31:0] lo, logic [31:0] hi,
                            int cx, int cy, logic [31:0] area);
        write_cfg(REG_DEGREE_X, dx);
        write_cfg(REG_DEGREE_Y, dy);
        write_cfg(REG_DEGREE_VALUE, dv);
        write_cfg(REG_MIN_VALUE, lo);
        write_cfg(REG_MAX_VALUE, hi);
        write_cfg(REG_CELLS_X, cx);
        write_cfg(REG_CELLS_Y, cy);
        write_cfg(REG_CELL_AREA, area);
    endtask

    // Offer one cell at a falling edge and hold it until accepted
    task automatic send_cell(logic [11:0] c, logic [11:0] r, logic [31:0] v,
                             logic [31:0] w, logic lst);
        lma_item_t it;
        while (gaps_on && $urandom_range(0, 99) < 34)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        col = c;
        row = r;
        cell_value = v;
        weight = w;
        last = lst;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        it.col = c;
        it.row = r;
        it.cell_value = v;
        it.weight = w;
        it.last = lst;
        board.note_cell(it);
        @(negedge clk);
    endtask

    // Let every pending moment drain, then a margin for the datapath
    task automatic drain();
        in_valid = 1'b0;
        while (board.moments_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // Random cells, mostly within the current grid; the phase closes on a last cell
    task automatic random_phase(int n);
        int cx, cy;
        longint span;
        logic [31:0] v, w;
        logic [11:0] c, r;
        cx = (board.cfg.cells_x == 0) ? 1 : int'(board.cfg.cells_x);
        cy = (board.cfg.cells_y == 0) ? 1 : int'(board.cfg.cells_y);
        if (cx > GRID_LIMIT) cx = GRID_LIMIT;
        if (cy > GRID_LIMIT) cy = GRID_LIMIT;
        span = longint'(board.cfg.max_value) - longint'(board.cfg.min_value);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                c = 12'($urandom);
                r = 12'($urandom);
                v = $urandom;
            end
            else
            begin
                c = 12'($urandom_range(0, cx - 1));
                r = 12'($urandom_range(0, cy - 1));
                if (span > 0)
                    v = 32'(longint'(board.cfg.min_value) + longint'($urandom % span));
                else
                    v = $urandom;
            end
            w = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 131072) - 65536;
            send_cell(c, r, v, w, (i == n - 1) || ($urandom_range(0, 9) == 0));
        end
        drain();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: field extremes
        send_cell(12'd0, 12'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_cell(12'hfff, 12'hfff, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_cell(12'd0, 12'd0, 32'h0000_8000, 32'h8000_0000, 1'b1);
        send_cell(12'd0, 12'd0, 32'h0001_0000, 32'h7fff_ffff, 1'b1);
        drain();

        // Zero cell counts, reversed bounds, zero area
        load_cfg(3, 2, 4, 32'h0001_0000, 32'hffff_0000, 0, 0, 32'd0);
        send_cell(12'd0, 12'd0, 32'h0000_1234, 32'h0001_0000, 1'b0);
        send_cell(12'd1, 12'd3, 32'h0000_1234, 32'h0001_0000, 1'b1);
        drain();

        // Counts at and above the grid limit, extreme bounds and area, index past the count
        load_cfg(15, 15, 15, 32'h8000_0000, 32'h7fff_ffff, 8191, 4096, 32'hffff_ffff);
        send_cell(12'd4095, 12'd0, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_cell(12'd2048, 12'd4095, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
        send_cell(12'd17, 12'd1234, 32'h0000_0000, 32'h7fff_ffff, 1'b1);
        drain();
        load_cfg(1, 1, 0, 32'hffff_0000, 32'h0001_0000, 3, 5, 32'hffff_ffff);
        send_cell(12'd2, 12'd4, 32'h0001_0000, 32'h7fff_ffff, 1'b0);
        send_cell(12'd3, 12'd5, 32'h0001_0000, 32'h8000_0000, 1'b1);
        drain();

        // Random phases over a spread of settings
        for (int ph = 0; ph < 10; ph++)
        begin
            gaps_on = (ph != 4);
            if (ph == 9)
                load_cfg(15, 15, 15, $urandom, $urandom, $urandom_range(0, 8191),
                         $urandom_range(0, 8191), $urandom);
            else
                load_cfg($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 5),
                         $urandom_range(0, 65536) - 131072, $urandom_range(0, 262144),
                         $urandom_range(1, 64), $urandom_range(1, 64),
                         ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 262144));
            random_phase((ph == 9) ? 25 : 70);
        end
        gaps_on = 1'b1;

        drain();
        $display("Covered %0d cells and %0d moments over fourteen register settings.",
                 board.cells_seen, board.moments_seen);
        if (board.errors == 0 && board.moments_due.size() == 0)
            $display("legendre_moment_accumulator test passed");
        else
            $display("legendre_moment_accumulator test failed");
        $finish;
    end
endmodule
